// ===== src/bcf_pkg.sv =====
`timescale 1ns / 1ps

package bcf_pkg;

    // curve parameter t in unsigned q1.16, one sign-free bit above the fraction
    localparam int unsigned T_W       = 17;
    localparam int unsigned SEG_W     = 6;
    localparam logic [SEG_W-1:0] SEG_RESET = 6'd9;
    localparam logic [SEG_W-1:0] SEG_MIN   = 6'd1;

    // restoring division of 2^16 by the segment count, one quotient bit a step
    localparam int unsigned DIV_STEPS = T_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    localparam logic [T_W-1:0] T_ONE  = 17'h10000;

    // bernstein terms per point (quadratic uses a zero fourth weight)
    localparam int unsigned MAC_TERMS = 4;
    localparam int unsigned K_W       = $clog2(MAC_TERMS);

    // weight widths: squares up to 2^32, cubes up to 2^48
    localparam int unsigned SQ_W  = 33;
    localparam int unsigned WGT_W = 49;
    localparam int unsigned LO_W  = 24;
    localparam int unsigned HI_W  = WGT_W - LO_W;

    // final right shifts after the low half has been folded in
    localparam int unsigned QUAD_SHIFT  = 32 - LO_W;
    localparam int unsigned CUBIC_SHIFT = 48 - LO_W;

    typedef struct packed {
        logic           in_rdy;
        logic           div_step;
        logic           sq;
        logic           wt;
        logic           mul;
        logic [K_W-1:0] k;
        logic           emit;
    } t_cmd;

    typedef struct packed {
        logic in_vld;
        logic out_free;
        logic last;
    } t_sts;

endpackage

// ===== src/bcf_curve_if.sv =====
`timescale 1ns / 1ps

interface bcf_curve_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;

    modport source (
        output valid, kind, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
        input  ready
    );

    modport sink (
        input  valid, kind, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
        output ready
    );
endinterface

// ===== src/bcf_point_if.sv =====
`timescale 1ns / 1ps

interface bcf_point_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [bcf_pkg::SEG_W-1:0]    sample_index;
    logic                         last;

    modport source (
        output valid, point_x, point_y, sample_index, last,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, sample_index, last,
        output ready
    );
endinterface

// ===== src/bcf_ctrl.sv =====
`timescale 1ns / 1ps

module bcf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bcf_pkg::t_sts i_sts,
    output bcf_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_WT   = 3'd3;
    localparam logic [2:0] S_MAC  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [bcf_pkg::CNT_W-1:0] DIV_LAST =
        bcf_pkg::CNT_W'(bcf_pkg::DIV_STEPS - 1);
    localparam logic [bcf_pkg::CNT_W-1:0] MAC_LAST =
        bcf_pkg::CNT_W'(bcf_pkg::MAC_TERMS - 1);

    logic [2:0]                r_state, n_state;
    logic [bcf_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_cmd.k      = r_cnt[bcf_pkg::K_W-1:0];
        case (r_state)
            S_IDLE: begin
                o_cmd.in_rdy = 1'b1;
                if (i_sts.in_vld) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SQ;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_WT;
            end
            S_WT: begin
                o_cmd.wt = 1'b1;
                n_state  = S_MAC;
                n_cnt    = '0;
            end
            S_MAC: begin
                o_cmd.mul = 1'b1;
                if (r_cnt == MAC_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last ? S_IDLE : S_SQ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== src/bcf_dp.sv =====
`timescale 1ns / 1ps

module bcf_dp #(
    parameter int COORD_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bcf_pkg::SEG_W-1:0] i_cfg_wdata,
    input  bcf_pkg::t_cmd             i_cmd,
    output bcf_pkg::t_sts             o_sts,
    bcf_curve_if.sink                 i_curve,
    bcf_point_if.source               o_point
);

    localparam int CW    = COORD_BITS + 2;          // coefficient scaled by 2 or 3
    localparam int PH_W  = CW + bcf_pkg::HI_W + 1;
    localparam int PL_W  = CW + bcf_pkg::LO_W + 1;
    localparam int ACC_W = CW + bcf_pkg::HI_W + 4;

    localparam int T_W   = bcf_pkg::T_W;
    localparam int SEG_W = bcf_pkg::SEG_W;

    localparam int SQ_W_EXT = bcf_pkg::SQ_W + T_W;

    // configuration
    logic [SEG_W-1:0] r_segments;

    // held curve
    logic                 r_kind;
    logic [SEG_W-1:0]     r_segs;
    logic signed [CW-1:0] r_cx [bcf_pkg::MAC_TERMS];
    logic signed [CW-1:0] r_cy [bcf_pkg::MAC_TERMS];

    // divider and t stepping
    logic [T_W-1:0]   r_dvd;
    logic [T_W-1:0]   r_q0;
    logic [SEG_W-1:0] r_rem;
    logic [SEG_W-1:0] r_racc;
    logic [T_W-1:0]   r_t;
    logic [T_W-1:0]   r_u;
    logic [SEG_W-1:0] r_idx;

    // weights
    logic [bcf_pkg::SQ_W-1:0]  r_uu, r_ut, r_tt;
    logic [bcf_pkg::WGT_W-1:0] r_w [bcf_pkg::MAC_TERMS];

    // products and sums
    logic signed [PH_W-1:0]  r_ph_x, r_ph_y;
    logic signed [PL_W-1:0]  r_pl_x, r_pl_y;
    logic                    r_prod_vld;
    logic signed [ACC_W-1:0] r_ah_x, r_ah_y, r_al_x, r_al_y;

    // output register
    logic                         r_out_vld;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [SEG_W-1:0]             r_oidx;
    logic                         r_olast;

    logic                    load;
    logic                    out_free;
    logic [SEG_W:0]          rem_sh;
    logic                    div_ge;
    logic [SEG_W:0]          racc_sum;
    logic                    step_ge;
    logic [2*T_W-1:0]        m_uu, m_ut, m_tt;
    logic [SQ_W_EXT-1:0]     m_c0, m_c1, m_c2, m_c3;
    logic [bcf_pkg::WGT_W-1:0] w_sel;
    logic signed [bcf_pkg::HI_W:0] w_hi;
    logic signed [bcf_pkg::LO_W:0] w_lo;
    logic signed [PH_W-1:0]  ph_x, ph_y;
    logic signed [PL_W-1:0]  pl_x, pl_y;
    logic signed [ACC_W-1:0] sum_x, sum_y, res_x, res_y;
    logic signed [CW-1:0]    in_c [2*bcf_pkg::MAC_TERMS];
    logic signed [CW-1:0]    c1x3, c1y3, c2x3, c2y3;

    assign load     = i_curve.valid && i_curve.ready;
    assign out_free = !r_out_vld || o_point.ready;

    assign i_curve.ready = i_cmd.in_rdy;
    assign o_sts.in_vld   = i_curve.valid;
    assign o_sts.out_free = out_free;
    assign o_sts.last     = (r_idx == r_segs);

    assign o_point.valid        = r_out_vld;
    assign o_point.point_x      = r_px;
    assign o_point.point_y      = r_py;
    assign o_point.sample_index = r_oidx;
    assign o_point.last         = r_olast;

    // sign-extend the incoming points, form three times each inner one for cubics
    always_comb begin
        in_c[0] = CW'(i_curve.p0_x);
        in_c[1] = CW'(i_curve.p0_y);
        in_c[2] = CW'(i_curve.p1_x);
        in_c[3] = CW'(i_curve.p1_y);
        in_c[4] = CW'(i_curve.p2_x);
        in_c[5] = CW'(i_curve.p2_y);
        in_c[6] = CW'(i_curve.p3_x);
        in_c[7] = CW'(i_curve.p3_y);
        c1x3    = in_c[2] + (in_c[2] <<< 1);
        c1y3    = in_c[3] + (in_c[3] <<< 1);
        c2x3    = in_c[4] + (in_c[4] <<< 1);
        c2y3    = in_c[5] + (in_c[5] <<< 1);
    end

    // divider step and t stepping
    always_comb begin
        rem_sh   = {r_rem, r_dvd[T_W-1]};
        div_ge   = (rem_sh >= {1'b0, r_segs});
        racc_sum = {1'b0, r_racc} + {1'b0, r_rem};
        step_ge  = (racc_sum >= {1'b0, r_segs});
    end

    // squares, then cubes
    always_comb begin
        m_uu = r_u * r_u;
        m_ut = r_u * r_t;
        m_tt = r_t * r_t;
        m_c0 = r_uu * r_u;
        m_c1 = r_uu * r_t;
        m_c2 = r_tt * r_u;
        m_c3 = r_tt * r_t;
    end

    // one weight times one control point, split in a high and a low half
    always_comb begin
        w_sel = r_w[i_cmd.k];
        w_hi  = $signed({1'b0, w_sel[bcf_pkg::WGT_W-1:bcf_pkg::LO_W]});
        w_lo  = $signed({1'b0, w_sel[bcf_pkg::LO_W-1:0]});
        ph_x  = w_hi * r_cx[i_cmd.k];
        ph_y  = w_hi * r_cy[i_cmd.k];
        pl_x  = w_lo * r_cx[i_cmd.k];
        pl_y  = w_lo * r_cy[i_cmd.k];
    end

    // fold the low half in with a floor shift, then the final floor shift
    always_comb begin
        sum_x = r_ah_x + (r_al_x >>> bcf_pkg::LO_W);
        sum_y = r_ah_y + (r_al_y >>> bcf_pkg::LO_W);
        res_x = r_kind ? (sum_x >>> bcf_pkg::CUBIC_SHIFT) : (sum_x >>> bcf_pkg::QUAD_SHIFT);
        res_y = r_kind ? (sum_y >>> bcf_pkg::CUBIC_SHIFT) : (sum_y >>> bcf_pkg::QUAD_SHIFT);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segments <= bcf_pkg::SEG_RESET;
            r_out_vld  <= 1'b0;
            r_prod_vld <= 1'b0;
            r_kind     <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_segments <= i_cfg_wdata;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (o_point.ready) begin
                r_out_vld <= 1'b0;
            end
            r_prod_vld <= i_cmd.mul;
            if (load) begin
                r_kind <= i_curve.kind;
                r_idx  <= '0;
            end else if (i_cmd.emit) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_segs    <= (r_segments == '0) ? bcf_pkg::SEG_MIN : r_segments;
            r_cx[0]   <= in_c[0];
            r_cy[0]   <= in_c[1];
            r_cx[1]   <= i_curve.kind ? c1x3 : (in_c[2] <<< 1);
            r_cy[1]   <= i_curve.kind ? c1y3 : (in_c[3] <<< 1);
            r_cx[2]   <= i_curve.kind ? c2x3 : in_c[4];
            r_cy[2]   <= i_curve.kind ? c2y3 : in_c[5];
            r_cx[3]   <= in_c[6];
            r_cy[3]   <= in_c[7];
            r_dvd     <= bcf_pkg::T_ONE;
            r_q0      <= '0;
            r_rem     <= '0;
            r_racc    <= '0;
            r_t       <= '0;
            r_u       <= bcf_pkg::T_ONE;
        end
        if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_q0  <= {r_q0[T_W-2:0], div_ge};
            r_rem <= div_ge ? SEG_W'(rem_sh - {1'b0, r_segs}) : rem_sh[SEG_W-1:0];
        end
        if (i_cmd.sq) begin
            r_uu <= m_uu[bcf_pkg::SQ_W-1:0];
            r_ut <= m_ut[bcf_pkg::SQ_W-1:0];
            r_tt <= m_tt[bcf_pkg::SQ_W-1:0];
        end
        if (i_cmd.wt) begin
            if (r_kind) begin
                r_w[0] <= m_c0[bcf_pkg::WGT_W-1:0];
                r_w[1] <= m_c1[bcf_pkg::WGT_W-1:0];
                r_w[2] <= m_c2[bcf_pkg::WGT_W-1:0];
                r_w[3] <= m_c3[bcf_pkg::WGT_W-1:0];
            end else begin
                r_w[0] <= bcf_pkg::WGT_W'(r_uu);
                r_w[1] <= bcf_pkg::WGT_W'(r_ut);
                r_w[2] <= bcf_pkg::WGT_W'(r_tt);
                r_w[3] <= '0;
            end
            r_ah_x <= '0;
            r_ah_y <= '0;
            r_al_x <= '0;
            r_al_y <= '0;
        end else if (r_prod_vld) begin
            r_ah_x <= r_ah_x + ACC_W'(r_ph_x);
            r_ah_y <= r_ah_y + ACC_W'(r_ph_y);
            r_al_x <= r_al_x + ACC_W'(r_pl_x);
            r_al_y <= r_al_y + ACC_W'(r_pl_y);
        end
        if (i_cmd.mul) begin
            r_ph_x <= ph_x;
            r_ph_y <= ph_y;
            r_pl_x <= pl_x;
            r_pl_y <= pl_y;
        end
        if (i_cmd.emit) begin
            r_px    <= res_x[COORD_BITS-1:0];
            r_py    <= res_y[COORD_BITS-1:0];
            r_oidx  <= r_idx;
            r_olast <= (r_idx == r_segs);
            r_racc  <= step_ge ? SEG_W'(racc_sum - {1'b0, r_segs}) : racc_sum[SEG_W-1:0];
            r_t     <= r_t + r_q0 + T_W'(step_ge);
            r_u     <= r_u - r_q0 - T_W'(step_ge);
        end
    end

endmodule

// ===== src/bezier_curve_flattener.sv =====
`timescale 1ns / 1ps
// a curve item is taken only while the sequencer is idle; its points follow the
// 17-step quotient of 2^16 by the segment count, each point after its 8-step
// weight/product sequence, and the next curve is taken once the last point is emitted
// the four products of each point share one set of multipliers, one term a step
// a point not yet taken from the output register holds the sequencer at the next output
// reset (synchronous, active low): controller idle, output empty, segments back to 9

module bezier_curve_flattener #(
    parameter int COORD_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // segment count register, written while idle
    input  logic                      i_cfg_we,
    input  logic [bcf_pkg::SEG_W-1:0] i_cfg_wdata,
    // curve items in, sampled points out
    bcf_curve_if.sink                 i_curve,
    bcf_point_if.source               o_point
);

    // command and status between the sequencer and the arithmetic
    bcf_pkg::t_cmd cmd;
    bcf_pkg::t_sts sts;

    // sequencer: idle -> divide -> per point (squares, weights, four products,
    // drain, output), looping until the last sample has been emitted
    bcf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // arithmetic: holds the curve, steps t by the quotient and remainder,
    // forms the bernstein weights and the exact weighted sums, owns the
    // output register so a finished point waits there while work goes on
    bcf_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_curve     (i_curve),
        .o_point     (o_point)
    );

endmodule

// ===== tb/tb_bezier_curve_flattener.sv =====
`timescale 1ns / 1ps

module tb_bezier_curve_flattener;

    localparam int CW = 24;

    // curve kinds as carried on the kind field
    localparam logic KIND_QUAD  = 1'b0;
    localparam logic KIND_CUBIC = 1'b1;

    // coordinate extremes of signed q15.8
    localparam logic signed [CW-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [CW-1:0] C_MIN = -24'sh800000;

    // cycles allowed after the last point for the controller to settle
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic                 kind;
        logic signed [CW-1:0] p0_x;
        logic signed [CW-1:0] p0_y;
        logic signed [CW-1:0] p1_x;
        logic signed [CW-1:0] p1_y;
        logic signed [CW-1:0] p2_x;
        logic signed [CW-1:0] p2_y;
        logic signed [CW-1:0] p3_x;
        logic signed [CW-1:0] p3_y;
    } t_curve;

    typedef struct packed {
        logic signed [CW-1:0]      x;
        logic signed [CW-1:0]      y;
        logic [bcf_pkg::SEG_W-1:0] idx;
        logic                      last;
    } t_point;

    // expected sampled points, worked out from each curve as it is taken
    class flattened_points;
        t_point pending_points[$];
        int     errors;
        int     checked;

        // bernstein evaluation of one curve at every sample, exact then floored
        function void note_curve(t_curve c, logic [bcf_pkg::SEG_W-1:0] seg_reg);
            longint unsigned     n;
            longint unsigned     t;
            longint unsigned     u;
            logic [63:0]         w[4];
            logic signed [CW-1:0] cx[4];
            logic signed [CW-1:0] cy[4];
            logic signed [95:0]  sx;
            logic signed [95:0]  sy;
            int                  sh;
            t_point              e;
            n = (seg_reg == 0) ? 1 : seg_reg;
            cx[0] = c.p0_x; cy[0] = c.p0_y;
            cx[1] = c.p1_x; cy[1] = c.p1_y;
            cx[2] = c.p2_x; cy[2] = c.p2_y;
            cx[3] = c.p3_x; cy[3] = c.p3_y;
            for (longint unsigned i = 0; i <= n; i++) begin
                t = (i * 64'd65536) / n;
                u = 64'd65536 - t;
                if (c.kind == KIND_CUBIC) begin
                    w[0] = u * u * u;
                    w[1] = 3 * u * u * t;
                    w[2] = 3 * u * t * t;
                    w[3] = t * t * t;
                    sh   = 48;
                end else begin
                    w[0] = u * u;
                    w[1] = 2 * u * t;
                    w[2] = t * t;
                    w[3] = 0;
                    sh   = 32;
                end
                sx = 0;
                sy = 0;
                for (int k = 0; k < 4; k++) begin
                    sx = sx + ($signed({1'b0, w[k]}) * cx[k]);
                    sy = sy + ($signed({1'b0, w[k]}) * cy[k]);
                end
                sx = sx >>> sh;
                sy = sy >>> sh;
                e.x    = sx[CW-1:0];
                e.y    = sy[CW-1:0];
                e.idx  = i[bcf_pkg::SEG_W-1:0];
                e.last = (i == n);
                pending_points.push_back(e);
            end
        endfunction

        function void check_point(t_point p);
            t_point e;
            if (pending_points.size() == 0) begin
                $display("%0t: point with nothing expected: x %0d y %0d idx %0d last %0b",
                         $time, p.x, p.y, p.idx, p.last);
                errors++;
                return;
            end
            e = pending_points.pop_front();
            checked++;
            if (p.x !== e.x) begin
                $display("%0t: point_x expected %0d got %0d (idx %0d)", $time, e.x, p.x, e.idx);
                errors++;
            end
            if (p.y !== e.y) begin
                $display("%0t: point_y expected %0d got %0d (idx %0d)", $time, e.y, p.y, e.idx);
                errors++;
            end
            if (p.idx !== e.idx) begin
                $display("%0t: sample_index expected %0d got %0d", $time, e.idx, p.idx);
                errors++;
            end
            if (p.last !== e.last) begin
                $display("%0t: last expected %0b got %0b (idx %0d)",
                         $time, e.last, p.last, e.idx);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [bcf_pkg::SEG_W-1:0] i_cfg_wdata;

    bcf_curve_if #(.COORD_BITS(CW)) curve_bus ();
    bcf_point_if #(.COORD_BITS(CW)) point_bus ();

    bezier_curve_flattener #(.COORD_BITS(CW)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_curve     (curve_bus),
        .o_point     (point_bus)
    );

    flattened_points           book;
    logic [bcf_pkg::SEG_W-1:0] seg_now;        // our copy of the segment register
    int                        send_idle_pct;  // chance per cycle that the sender holds off
    int                        recv_stall_pct; // chance per cycle that the receiver stalls
    int                        curves_taken;

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // receiver back-pressure, changed on the falling edge only
    always @(negedge i_clk) begin
        point_bus.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // every point taken at a rising edge is checked against the oldest expectation
    always @(posedge i_clk) begin
        t_point p;
        if (i_rst_n && point_bus.valid && point_bus.ready) begin
            p.x    = point_bus.point_x;
            p.y    = point_bus.point_y;
            p.idx  = point_bus.sample_index;
            p.last = point_bus.last;
            book.check_point(p);
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("tb_bezier_curve_flattener: done, errors");
        $finish;
    end

    // present one curve item, with random hold-off first; valid is left high on return
    task automatic send_curve(input t_curve c);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            curve_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        curve_bus.valid <= 1'b1;
        curve_bus.kind  <= c.kind;
        curve_bus.p0_x  <= c.p0_x;
        curve_bus.p0_y  <= c.p0_y;
        curve_bus.p1_x  <= c.p1_x;
        curve_bus.p1_y  <= c.p1_y;
        curve_bus.p2_x  <= c.p2_x;
        curve_bus.p2_y  <= c.p2_y;
        curve_bus.p3_x  <= c.p3_x;
        curve_bus.p3_y  <= c.p3_y;
        do @(posedge i_clk); while (!(curve_bus.valid && curve_bus.ready));
        book.note_curve(c, seg_now);
        curves_taken++;
        @(negedge i_clk);
    endtask

    // drop valid, let every expected point arrive, then let the controller settle
    task automatic wait_drained();
        curve_bus.valid <= 1'b0;
        while (book.pending_points.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // only called once the block is idle
    task automatic write_segments(input logic [bcf_pkg::SEG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        seg_now      = v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_curve make_curve(input logic k,
                                          input logic signed [CW-1:0] a, b, c, d,
                                          input logic signed [CW-1:0] e, f, g, h);
        t_curve r;
        r.kind = k;
        r.p0_x = a; r.p0_y = b;
        r.p1_x = c; r.p1_y = d;
        r.p2_x = e; r.p2_y = f;
        r.p3_x = g; r.p3_y = h;
        return r;
    endfunction

    // mostly full-range values, with small values and the extremes mixed in
    function automatic logic signed [CW-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            6:       return $signed(CW'(r[9:0])) - 512;
            7:       return C_MAX;
            8:       return C_MIN;
            9:       return r[0] ? -1 : 0;
            default: return r[CW-1:0];
        endcase
    endfunction

    function automatic t_curve rand_curve();
        return make_curve(logic'($urandom_range(1)),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endfunction

    initial begin
        int                        idle_send[4];
        int                        idle_recv[4];
        logic [bcf_pkg::SEG_W-1:0] seg_plan[12];

        idle_send       = '{0, 66, 0, 35};
        idle_recv       = '{0, 0, 66, 35};
        seg_plan        = '{1, 0, 4, 63, 2, 9, 17, 3, 32, 6, 11, 47};
        book            = new();
        seg_now         = bcf_pkg::SEG_RESET;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        curves_taken    = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        point_bus.ready = 1'b0;
        curve_bus.valid = 1'b0;
        curve_bus.kind  = KIND_QUAD;
        curve_bus.p0_x  = '0;
        curve_bus.p0_y  = '0;
        curve_bus.p1_x  = '0;
        curve_bus.p1_y  = '0;
        curve_bus.p2_x  = '0;
        curve_bus.p2_y  = '0;
        curve_bus.p3_x  = '0;
        curve_bus.p3_y  = '0;

        // reset held, then released on a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed curves at the reset segment count
        send_curve(make_curve(KIND_QUAD, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0, 0));
        send_curve(make_curve(KIND_QUAD, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0, 0));
        send_curve(make_curve(KIND_CUBIC, C_MAX, C_MAX, C_MAX, C_MAX,
                              C_MAX, C_MAX, C_MAX, C_MAX));
        send_curve(make_curve(KIND_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN,
                              C_MIN, C_MIN, C_MIN, C_MIN));
        // quadratic with a swinging control point and junk in p3, which must be ignored
        send_curve(make_curve(KIND_QUAD, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                              24'sh5A5A5A, -24'sh2A5A5A));
        send_curve(make_curve(KIND_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN,
                              C_MIN, C_MAX, C_MAX, C_MIN));
        send_curve(make_curve(KIND_QUAD, 0, 0, 0, 0, 0, 0, 0, 0));
        send_curve(make_curve(KIND_CUBIC, -1, -1, -1, -1, -1, -1, -1, -1));
        // tiny spans, where flooring towards minus infinity shows
        send_curve(make_curve(KIND_CUBIC, -1, 1, 0, 0, 0, 0, 1, -1));
        send_curve(make_curve(KIND_QUAD, -3, -7, 5, -2, -1, 3, 0, 0));

        // zero segments behaves as one: start and end point only
        wait_drained();
        write_segments(0);
        send_curve(make_curve(KIND_QUAD, C_MAX, C_MIN, 100, -100, C_MIN, C_MAX, 0, 0));
        send_curve(make_curve(KIND_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN, -5, 5, C_MAX, C_MIN));

        // full-scale segments: the most points per curve
        wait_drained();
        write_segments(63);
        send_curve(make_curve(KIND_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX,
                              C_MAX, C_MIN, C_MIN, C_MAX));
        send_curve(make_curve(KIND_QUAD, C_MIN, -1, C_MAX, 1, -1, C_MIN, C_MAX, C_MAX));

        // random curves across four idling phases, segment count changed per block
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_send[ph];
            recv_stall_pct = idle_recv[ph];
            for (int blk = 0; blk < 3; blk++) begin
                wait_drained();
                write_segments(seg_plan[ph * 3 + blk]);
                for (int n = 0; n < 36; n++) begin
                    send_curve(rand_curve());
                    // sender holds off until every point is out, once per phase
                    if (blk == 1 && n == 17) wait_drained();
                end
            end
        end

        wait_drained();
        $display("tb: %0d curves flattened, %0d points checked, segment counts 0 to 63,",
                 curves_taken, book.checked);
        $display("tb: quadratic and cubic, sender and receiver idling in four phases");
        if (book.errors == 0) begin
            $display("tb_bezier_curve_flattener: done, clean");
        end else begin
            $display("tb_bezier_curve_flattener: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bcf_pkg.sv
src/bcf_curve_if.sv
src/bcf_point_if.sv
src/bcf_ctrl.sv
src/bcf_dp.sv
src/bezier_curve_flattener.sv
tb/tb_bezier_curve_flattener.sv
